// ===== hdl/irpd_pkg.sv =====
// Shared types and constants of the infrared pulse-distance transmitter.
// Holds the register map, reset values, segment phase type and the structs
// passed between the configuration registers, the frame engine and the top level.
package irpd_pkg;

	localparam int MAX_COMMAND_BITS_DEF = 48;
	localparam int CMD_W                = 48;
	localparam int LEN_W                = 16;
	localparam int RPT_W                = 8;
	localparam int BCNT_W               = 6;
	localparam int CFG_IDX_W            = 4;
	localparam int CFG_DATA_W           = 16;

	localparam logic [CFG_IDX_W-1:0] REG_START_MARK  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SPACE = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_CNT  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 4'd7;

	localparam logic [LEN_W-1:0]  RST_START_MARK  = 16'd4500;
	localparam logic [LEN_W-1:0]  RST_START_SPACE = 16'd4300;
	localparam logic [LEN_W-1:0]  RST_BIT_MARK    = 16'd700;
	localparam logic [LEN_W-1:0]  RST_ONE_SPACE   = 16'd1500;
	localparam logic [LEN_W-1:0]  RST_ZERO_SPACE  = 16'd450;
	localparam logic [RPT_W-1:0]  RST_REPEAT_CNT  = 8'd2;
	localparam logic [LEN_W-1:0]  RST_REPEAT_GAP  = 16'd5500;
	localparam logic [BCNT_W-1:0] RST_BIT_COUNT   = 6'd48;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SMARK,
		PH_SSPACE,
		PH_BMARK,
		PH_BSPACE,
		PH_TMARK,
		PH_GAP
	} phase_t;

	typedef struct packed {
		logic [LEN_W-1:0]  start_mark_len;
		logic [LEN_W-1:0]  start_space_len;
		logic [LEN_W-1:0]  bit_mark_len;
		logic [LEN_W-1:0]  one_space_len;
		logic [LEN_W-1:0]  zero_space_len;
		logic [RPT_W-1:0]  repeat_count;
		logic [LEN_W-1:0]  repeat_gap_len;
		logic [BCNT_W-1:0] bit_count;
	} cfg_t;

	typedef struct packed {
		logic carrier_on;
		logic busy;
		logic done;
	} res_t;

endpackage

// ===== hdl/ir_pulse_distance_transmitter.sv =====
// Infrared pulse-distance transmitter: each input word is either a one-microsecond
// tick or a start request, and each produces one result word carrying the carrier
// envelope, the busy flag and an end-of-frame pulse. One word is taken every clock
// cycle while results are taken; a word passes an input register and one pass of
// frame logic into the result register, where its result is presented. A result
// word that is not taken holds the input register, and the input then stalls.
// That pass resolves any run of empty segments at once, using two priority searches
// over the command bits.
// Depends on irpd_pkg, irpd_regs, irpd_seek and irpd_core.
module ir_pulse_distance_transmitter import irpd_pkg::*; #(
	parameter int MAX_COMMAND_BITS = MAX_COMMAND_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic [CMD_W-1:0]      command_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  carrier_on,
	output logic                  busy_res,
	output logic                  frame_done,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t             cfg;
	res_t             res;
	logic             valid_s1;
	logic             func_s1;
	logic [CMD_W-1:0] word_s1;
	logic             valid_s2;
	res_t             res_s2;
	logic             adv;

	assign cfg_ready = 1'b1;

	irpd_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The word in the input register moves on whenever the result register is free or its word is being taken.
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			word_s1 <= command_word;
		end
	end

	irpd_core #(.MAX_COMMAND_BITS(MAX_COMMAND_BITS)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.func         (func_s1),
		.command_word (word_s1),
		.cfg          (cfg),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign carrier_on = res_s2.carrier_on;
	assign busy_res   = res_s2.busy;
	assign frame_done = res_s2.done;

endmodule

// ===== hdl/irpd_regs.sv =====
// Configuration register file of the infrared pulse-distance transmitter.
// Depends on irpd_pkg for the register map, reset values and cfg_t.
module irpd_regs import irpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_mark_len  <= RST_START_MARK;
			cfg_q.start_space_len <= RST_START_SPACE;
			cfg_q.bit_mark_len    <= RST_BIT_MARK;
			cfg_q.one_space_len   <= RST_ONE_SPACE;
			cfg_q.zero_space_len  <= RST_ZERO_SPACE;
			cfg_q.repeat_count    <= RST_REPEAT_CNT;
			cfg_q.repeat_gap_len  <= RST_REPEAT_GAP;
			cfg_q.bit_count       <= RST_BIT_COUNT;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_MARK:  cfg_q.start_mark_len  <= wr_data;
				REG_START_SPACE: cfg_q.start_space_len <= wr_data;
				REG_BIT_MARK:    cfg_q.bit_mark_len    <= wr_data;
				REG_ONE_SPACE:   cfg_q.one_space_len   <= wr_data;
				REG_ZERO_SPACE:  cfg_q.zero_space_len  <= wr_data;
				REG_REPEAT_CNT:  cfg_q.repeat_count    <= wr_data[RPT_W-1:0];
				REG_REPEAT_GAP:  cfg_q.repeat_gap_len  <= wr_data;
				REG_BIT_COUNT:   cfg_q.bit_count       <= wr_data[BCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/irpd_seek.sv =====
// Finds the first command bit, in sending order, whose space is not empty.
// Searches the positions from lo up to but excluding hi. Needs no package.
module irpd_seek #(
	parameter int N = 48,
	localparam int CW = $clog2(N + 1),
	localparam int IW = $clog2(N)
) (
	input  logic [N-1:0]  bits,
	input  logic [CW-1:0] lo,
	input  logic [CW-1:0] hi,
	output logic          found,
	output logic [IW-1:0] idx
);

	logic [N-1:0] cand;
	logic [N-1:0] first;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			cand[i] = bits[i] && (CW'(i) >= lo) && (CW'(i) < hi);
		end
		// Isolate the lowest candidate, then encode it.
		first = cand & (~cand + N'(1));
		idx   = '0;
		for (int i = 0; i < N; i++) begin
			if (first[i]) begin
				idx = idx | IW'(i);
			end
		end
		found = |cand;
	end

endmodule

// ===== hdl/irpd_core.sv =====
// Frame engine: segment state, tick timer and the single-pass resolution of
// which segment comes next, skipping empty ones. Depends on irpd_pkg and irpd_seek.
module irpd_core import irpd_pkg::*; #(
	parameter int MAX_COMMAND_BITS = MAX_COMMAND_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             func,
	input  logic [CMD_W-1:0] command_word,
	input  cfg_t             cfg,
	output res_t             res
);

	localparam int CW = $clog2(MAX_COMMAND_BITS + 1);
	localparam int IW = $clog2(MAX_COMMAND_BITS);
	localparam int WW = (MAX_COMMAND_BITS > CMD_W) ? MAX_COMMAND_BITS : CMD_W;
	localparam logic [7:0] MAX_BITS8 = 8'(MAX_COMMAND_BITS);

	phase_t                      phase_q;
	logic [LEN_W-1:0]            timer_q;
	logic [CW-1:0]               k_q;
	logic [CW-1:0]               nb_q;
	logic [RPT_W-1:0]            rep_q;
	logic [MAX_COMMAND_BITS-1:0] cmd_q;

	logic [WW-1:0]               word_wide;
	logic [MAX_COMMAND_BITS-1:0] word_m;
	logic [MAX_COMMAND_BITS-1:0] rev_new, rev_lat, q_new, q_lat, rev_sel;
	logic                        sm_nz, ss_nz, bm_nz, one_nz, zero_nz, gap_nz;
	logic [CW-1:0]               nb_new, nb1, kbits;
	logic                        found_a, found_b;
	logic [IW-1:0]               idx_a, idx_b;
	logic                        start_idle, expire;
	logic                        e_sm, e_ss, e_bsp, e_bits, e_gap, e_rep;
	logic                        sp_cur_nz, at_ss, at_bits, bits_in, at_tm, at_gap, at_rep;
	phase_t                      p1_phase, p2_phase, nx_phase;
	logic [CW-1:0]               p1_k, p2_k, nx_k, nx_nb;
	logic [RPT_W-1:0]            nx_rep, rep_plus;
	logic [LEN_W-1:0]            nx_timer, seg_len;
	logic                        entered, done;

	function automatic logic is_mark(phase_t ph);
		return (ph == PH_SMARK) || (ph == PH_BMARK) || (ph == PH_TMARK);
	endfunction

	// Bits at and above MAX_COMMAND_BITS are dropped; the word is reversed so that position k is sent k-th, MSB first.
	always_comb begin
		word_wide = WW'(command_word);
		word_m    = word_wide[MAX_COMMAND_BITS-1:0];
		for (int i = 0; i < MAX_COMMAND_BITS; i++) begin
			rev_new[i] = word_m[MAX_COMMAND_BITS-1-i];
			rev_lat[i] = cmd_q[MAX_COMMAND_BITS-1-i];
			q_new[i]   = rev_new[i] ? one_nz : zero_nz;
			q_lat[i]   = rev_lat[i] ? one_nz : zero_nz;
		end
	end

	assign sm_nz   = cfg.start_mark_len != '0;
	assign ss_nz   = cfg.start_space_len != '0;
	assign bm_nz   = cfg.bit_mark_len != '0;
	assign one_nz  = cfg.one_space_len != '0;
	assign zero_nz = cfg.zero_space_len != '0;
	assign gap_nz  = cfg.repeat_gap_len != '0;

	assign nb_new = ({2'b00, cfg.bit_count} > MAX_BITS8) ? CW'(MAX_COMMAND_BITS)
	                                                     : CW'(cfg.bit_count);

	assign start_idle = func && (phase_q == PH_IDLE);
	assign expire     = !func && (phase_q != PH_IDLE) && (timer_q <= LEN_W'(1));

	assign e_sm   = start_idle;
	assign e_ss   = expire && (phase_q == PH_SMARK);
	assign e_bsp  = expire && (phase_q == PH_BMARK);
	assign e_bits = expire && ((phase_q == PH_SSPACE) || (phase_q == PH_BSPACE));
	assign e_gap  = expire && (phase_q == PH_TMARK);
	assign e_rep  = expire && (phase_q == PH_GAP);

	assign kbits = (!func && ((phase_q == PH_BMARK) || (phase_q == PH_BSPACE)))
	               ? k_q + CW'(1) : '0;
	assign nb1   = func ? nb_new : nb_q;

	irpd_seek #(.N(MAX_COMMAND_BITS)) u_seek_cur (
		.bits  (func ? q_new : q_lat),
		.lo    (kbits),
		.hi    (nb1),
		.found (found_a),
		.idx   (idx_a)
	);

	irpd_seek #(.N(MAX_COMMAND_BITS)) u_seek_rep (
		.bits  (q_lat),
		.lo    ('0),
		.hi    (nb_new),
		.found (found_b),
		.idx   (idx_b)
	);

	assign sp_cur_nz = q_lat[k_q[IW-1:0]];

	// Rest of the current repetition, from the point where it is entered.
	always_comb begin
		at_ss   = (e_sm && !sm_nz) || e_ss;
		at_bits = (at_ss && !ss_nz) || (e_bsp && !sp_cur_nz) || e_bits;
		bits_in = kbits < nb1;
		at_tm   = at_bits && !(bits_in && (bm_nz || found_a));
		at_gap  = (at_tm && !bm_nz) || e_gap;
		at_rep  = (at_gap && !gap_nz) || e_rep;
		p1_k    = k_q;
		if (e_sm && sm_nz) begin
			p1_phase = PH_SMARK;
		end else if (at_ss && ss_nz) begin
			p1_phase = PH_SSPACE;
		end else if (e_bsp && sp_cur_nz) begin
			p1_phase = PH_BSPACE;
		end else if (at_bits && bits_in && bm_nz) begin
			p1_phase = PH_BMARK;
			p1_k     = kbits;
		end else if (at_bits && bits_in && found_a) begin
			p1_phase = PH_BSPACE;
			p1_k     = CW'(idx_a);
		end else if (at_tm && bm_nz) begin
			p1_phase = PH_TMARK;
		end else if (at_gap && gap_nz) begin
			p1_phase = PH_GAP;
		end else begin
			p1_phase = PH_IDLE;
		end
	end

	// First segment of a fresh repetition; idle means the repetition is empty.
	always_comb begin
		p2_k = '0;
		if (sm_nz) begin
			p2_phase = PH_SMARK;
		end else if (ss_nz) begin
			p2_phase = PH_SSPACE;
		end else if ((nb_new != '0) && bm_nz) begin
			p2_phase = PH_BMARK;
		end else if ((nb_new != '0) && found_b) begin
			p2_phase = PH_BSPACE;
			p2_k     = CW'(idx_b);
		end else if (bm_nz) begin
			p2_phase = PH_TMARK;
		end else if (gap_nz) begin
			p2_phase = PH_GAP;
		end else begin
			p2_phase = PH_IDLE;
		end
	end

	assign rep_plus = rep_q + RPT_W'(1);

	always_comb begin
		nx_phase = phase_q;
		nx_k     = k_q;
		nx_nb    = nb_q;
		nx_rep   = rep_q;
		entered  = 1'b0;
		done     = 1'b0;
		if (start_idle) begin
			nx_rep  = '0;
			nx_nb   = nb_new;
			nx_k    = p1_k;
			entered = 1'b1;
			if ((cfg.repeat_count == '0) || at_rep) begin
				nx_phase = PH_IDLE;
				done     = 1'b1;
			end else begin
				nx_phase = p1_phase;
			end
		end else if (expire) begin
			entered = 1'b1;
			if (!at_rep) begin
				nx_phase = p1_phase;
				nx_k     = p1_k;
			end else begin
				nx_rep = rep_plus;
				if ((rep_plus >= cfg.repeat_count) || (p2_phase == PH_IDLE)) begin
					nx_phase = PH_IDLE;
					done     = 1'b1;
				end else begin
					nx_phase = p2_phase;
					nx_k     = p2_k;
					nx_nb    = nb_new;
				end
			end
		end
	end

	assign rev_sel = func ? rev_new : rev_lat;

	always_comb begin
		case (nx_phase)
			PH_SMARK:           seg_len = cfg.start_mark_len;
			PH_SSPACE:          seg_len = cfg.start_space_len;
			PH_BMARK, PH_TMARK: seg_len = cfg.bit_mark_len;
			PH_BSPACE: begin
				seg_len = rev_sel[nx_k[IW-1:0]] ? cfg.one_space_len : cfg.zero_space_len;
			end
			PH_GAP:             seg_len = cfg.repeat_gap_len;
			default:            seg_len = '0;
		endcase
	end

	always_comb begin
		if (entered) begin
			nx_timer = seg_len;
		end else if (!func && (timer_q != '0)) begin
			nx_timer = timer_q - LEN_W'(1);
		end else begin
			nx_timer = timer_q;
		end
	end

	always_comb begin
		if (!func && (phase_q == PH_IDLE)) begin
			res = '0;
		end else if (start_idle) begin
			res.carrier_on = is_mark(nx_phase);
			res.busy       = nx_phase != PH_IDLE;
			res.done       = done;
		end else begin
			res.carrier_on = is_mark(phase_q);
			res.busy       = 1'b1;
			res.done       = done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			k_q     <= '0;
			nb_q    <= '0;
			rep_q   <= '0;
		end else if (step) begin
			phase_q <= nx_phase;
			timer_q <= nx_timer;
			k_q     <= nx_k;
			nb_q    <= nx_nb;
			rep_q   <= nx_rep;
		end
	end

	always_ff @(posedge clk) begin
		if (step && start_idle) begin
			cmd_q <= word_m;
		end
	end

endmodule

// ===== hdl/irpd_check.sv =====
// Port-level checks for the infrared pulse-distance transmitter, bound to its top level.
// Needs no package.
module irpd_check (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic carrier_on,
	input logic busy_res,
	input logic frame_done,
	input logic cfg_valid,
	input logic cfg_ready
);

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({carrier_on, busy_res, frame_done}))
		else $error("result word changed while stalled");

	// Register writes are never held off.
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write held off");

	// The carrier is only enabled while a frame is in progress.
	a_mark_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && carrier_on |-> busy_res)
		else $error("carrier on while not busy");

	// Input is held off only by a result word that is not being taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without back-pressure");

endmodule

bind ir_pulse_distance_transmitter irpd_check u_irpd_check (.*);
